// ----- sv/dnpc_pkg.sv -----
// Shared types and constants for the disc neighbour pixel count block.
package dnpc_pkg;

  // Configuration port address width: four 32-bit registers at 4*i.
  localparam int ADDR_W = 4;

  // Saturation value of the neighbour count.
  localparam int COUNT_MAX = 1023;

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register reset values.
  localparam logic [8:0] IMAGE_ROWS_RST = 9'd256;
  localparam logic [8:0] IMAGE_COLS_RST = 9'd256;
  localparam logic [9:0] HIGH_COUNT_RST = 10'd20;
  localparam logic [9:0] COUNT_THRESH_RST = 10'd10;

  typedef enum logic [1:0] {
    REG_IMAGE_ROWS   = 2'd0,
    REG_IMAGE_COLS   = 2'd1,
    REG_HIGH_COUNT   = 2'd2,
    REG_COUNT_THRESH = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [8:0] image_rows;
    logic [8:0] image_cols;
    logic [9:0] high_count_value;
    logic [9:0] count_threshold;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel_row;
    logic [7:0] pixel_col;
    logic       pixel_set;
    logic [9:0] nn_distance_q4;
  } item_t;

  typedef struct packed {
    logic [9:0] neighbour_count;
    logic [9:0] k_value;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_W_RD,
    ST_W_WR,
    ST_Q_RAD,
    ST_Q_SQR,
    ST_Q_ROW,
    ST_Q_DRAIN,
    ST_Q_DONE
  } state_t;

endpackage

// ----- sv/dnpc_cfg_regs.sv -----
// Configuration register file on an APB-style port.
module dnpc_cfg_regs import dnpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_rows       <= IMAGE_ROWS_RST;
      cfg.image_cols       <= IMAGE_COLS_RST;
      cfg.high_count_value <= HIGH_COUNT_RST;
      cfg.count_threshold  <= COUNT_THRESH_RST;
    end else if (wr_en) begin
      case (idx)
        REG_IMAGE_ROWS:   cfg.image_rows       <= pwdata[8:0];
        REG_IMAGE_COLS:   cfg.image_cols       <= pwdata[8:0];
        REG_HIGH_COUNT:   cfg.high_count_value <= pwdata[9:0];
        REG_COUNT_THRESH: cfg.count_threshold  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_ROWS:   prdata = {23'd0, cfg.image_rows};
      REG_IMAGE_COLS:   prdata = {23'd0, cfg.image_cols};
      REG_HIGH_COUNT:   prdata = {22'd0, cfg.high_count_value};
      REG_COUNT_THRESH: prdata = {22'd0, cfg.count_threshold};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// ----- sv/disc_neighbour_pixel_count.sv -----
// Top level: bitmap row memory, query sequencer and disc counting pipeline.
//
// Usage
//   item channel (item_valid/item_ready/item): cmd CMD_WRITE stores one pixel,
//   cmd CMD_QUERY counts the set pixels inside the disc around a centre pixel.
//   result channel (result_valid/result_ready/result): one beat per query,
//   none per write. Registers sit on the APB-style port; the user must see
//   that they are written only while the block is idle; the block does not enforce it.
// Timing
//   The bitmap lives in one memory of MAX_ROWS rows, each row one word of
//   MAX_COLS bits, read through a registered output. A write is a row
//   read-modify-write through ST_W_RD and ST_W_WR before the next accept.
//   A query reads one row word per cycle for offsets -span..span, where
//   span = floor(radius), at most the radius limit (15 by default); it
//   passes ST_Q_RAD, ST_Q_SQR, ST_Q_ROW, ST_Q_DRAIN and ST_Q_DONE, which loads
//   the result register, and the next item is taken back in ST_IDLE.
// Reset
//   After rst the memory is cleared one row per cycle, all MAX_ROWS rows
//   (256 by default); item_ready stays low meanwhile, register writes are taken.
// Stall
//   A finished result waits in the output register; writes keep being
//   accepted, and a following query holds in its last state until that
//   result beat is taken.
module disc_neighbour_pixel_count import dnpc_pkg::*; #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_ready,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int WIN     = 2 * MAX_RADIUS + 1;
  localparam int EXT_W   = MAX_COLS + 2 * MAX_RADIUS;
  localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
  localparam int OFF_W   = RAD_W + 1;
  localparam int RQ_MAX  = MAX_RADIUS * 16;
  localparam int RQ_W    = $clog2(RQ_MAX + 1);
  localparam int LIM_W   = 2 * RQ_W - 8;
  localparam int ACC_W   = $clog2(WIN * WIN + 1);
  localparam int ROW_CAP = (MAX_ROWS < 511) ? MAX_ROWS : 511;
  localparam int COL_CAP = (MAX_COLS < 511) ? MAX_COLS : 511;

  cfg_t cfg;

  dnpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------- state
  state_t state, state_next;
  logic [AW-1:0] clr_row;
  item_t req;

  logic [RQ_W-1:0]         rad_q4;
  logic [LIM_W-1:0]        lim;
  logic [RAD_W-1:0]        span;
  logic signed [OFF_W-1:0] ioff;
  logic [WIN-1:0]          col_mask;

  logic           s1_v, s2_v;
  logic [WIN-1:0] s1_mask, s2_bits;
  logic [ACC_W-1:0] acc;

  // ---------------------------------------------------------------- memory
  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rdata;
  logic                mem_re, mem_we;
  logic [AW-1:0]       mem_raddr, mem_waddr;
  logic [MAX_COLS-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------- derived values
  logic [8:0]  rows_eff, cols_eff;
  logic [11:0] rad3;
  logic [RQ_W-1:0] rad_q4_c;
  logic [2*RQ_W-1:0] rad_sq;
  logic [RAD_W-1:0] span_c;
  logic [RAD_W-1:0] abs_i;
  logic [2*RAD_W-1:0] isq;
  logic [WIN-1:0] disc_mask;
  logic [WIN-1:0] col_mask_c;
  int             row_pos;
  logic           row_ok;
  logic           wr_in_map;
  logic           load_result;
  logic [EXT_W-1:0] ext_row;
  logic [EXT_W-1:0] ext_shift;
  logic [9:0]     count_sat;
  logic [9:0]     k_c;

  assign rows_eff = (int'(cfg.image_rows) > ROW_CAP) ? 9'(ROW_CAP) : cfg.image_rows;
  assign cols_eff = (int'(cfg.image_cols) > COL_CAP) ? 9'(COL_CAP) : cfg.image_cols;

  // Radius in Q.4: three times the distance, saturated at the radius limit.
  assign rad3     = {2'd0, req.nn_distance_q4} + {1'b0, req.nn_distance_q4, 1'b0};
  assign rad_q4_c = (int'(rad3) > RQ_MAX) ? RQ_W'(RQ_MAX) : RQ_W'(rad3);
  assign rad_sq   = rad_q4 * rad_q4;
  assign span_c   = RAD_W'(rad_q4 >> 4);

  // Disc test for the current row offset: (i*i + j*j) * 256 <= rad^2 reduces
  // to i*i + j*j <= floor(rad^2 / 256), since the left side is a multiple of 256.
  assign abs_i = ioff[OFF_W-1] ? RAD_W'(-ioff) : RAD_W'(ioff);
  assign isq   = abs_i * abs_i;

  always_comb begin
    for (int w = 0; w < WIN; w++) begin
      disc_mask[w] = ((int'(isq) + (w - MAX_RADIUS) * (w - MAX_RADIUS)) <= int'(lim))
                     && !((ioff == '0) && (w == MAX_RADIUS));
    end
  end

  // Column clipping of the window, fixed for the whole query.
  always_comb begin
    for (int w = 0; w < WIN; w++) begin
      col_mask_c[w] = ((int'(req.pixel_col) + w - MAX_RADIUS) >= 0)
                      && ((int'(req.pixel_col) + w - MAX_RADIUS) < int'(cols_eff));
    end
  end

  assign row_pos   = int'(req.pixel_row) + int'(ioff);
  assign row_ok    = (row_pos >= 0) && (row_pos < int'(rows_eff));
  assign wr_in_map = (int'(item.pixel_row) < MAX_ROWS) && (int'(item.pixel_col) < MAX_COLS);

  // Window of the row word centred on the query column, zero padded.
  assign ext_row   = {{MAX_RADIUS{1'b0}}, rdata, {MAX_RADIUS{1'b0}}};
  assign ext_shift = ext_row >> req.pixel_col;

  assign count_sat = (int'(acc) > COUNT_MAX) ? 10'(COUNT_MAX) : 10'(acc);
  assign k_c       = (count_sat > cfg.count_threshold) ? cfg.high_count_value : count_sat;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_row <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_row <= clr_row + AW'(1);
      end
    end
  end

  always_comb begin
    state_next  = state;
    item_ready  = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = AW'(row_pos);
    mem_we      = 1'b0;
    mem_waddr   = AW'(req.pixel_row);
    mem_wdata   = rdata;
    load_result = 1'b0;
    mem_wdata[CAW'(req.pixel_col)] = req.pixel_set;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_row;
        mem_wdata = '0;
        if (clr_row == AW'(MAX_ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item.cmd == CMD_QUERY) begin
            state_next = ST_Q_RAD;
          end else if (wr_in_map) begin
            state_next = ST_W_RD;
          end
        end
      end
      ST_W_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = AW'(req.pixel_row);
        state_next = ST_W_WR;
      end
      ST_W_WR: begin
        mem_we     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_Q_RAD: state_next = ST_Q_SQR;
      ST_Q_SQR: state_next = ST_Q_ROW;
      ST_Q_ROW: begin
        mem_re = row_ok;
        if (ioff == $signed({1'b0, span})) begin
          state_next = ST_Q_DRAIN;
        end
      end
      ST_Q_DRAIN: begin
        if (!s1_v && !s2_v) begin
          state_next = ST_Q_DONE;
        end
      end
      ST_Q_DONE: begin
        if (!result_valid || result_ready) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      req <= item;
    end
    if (state == ST_Q_RAD) begin
      rad_q4   <= rad_q4_c;
      col_mask <= col_mask_c;
    end
    if (state == ST_Q_SQR) begin
      lim  <= LIM_W'(rad_sq >> 8);
      span <= span_c;
      ioff <= OFF_W'(0) - OFF_W'(span_c);
      acc  <= '0;
    end
    if (state == ST_Q_ROW) begin
      ioff    <= ioff + OFF_W'(1);
      s1_mask <= row_ok ? (disc_mask & col_mask) : '0;
    end
    if (s1_v) begin
      s2_bits <= ext_shift[WIN-1:0] & s1_mask;
    end
    if (s2_v) begin
      acc <= acc + ACC_W'($countones(s2_bits));
    end
    if (load_result) begin
      result.neighbour_count <= count_sat;
      result.k_value         <= k_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_v <= (state == ST_Q_ROW);
      s2_v <= s1_v;
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- checks
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> (state == ST_CLEAR))
    else $error("clearing pass does not follow reset");

  a_pipe_empty_at_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_Q_DONE) |-> (!s1_v && !s2_v))
    else $error("count taken while rows still in flight");

  a_mem_one_access: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !mem_re)
    else $error("row read and write in the same cycle");

  a_k_rule: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.neighbour_count > cfg.count_threshold) ?
                      (result.k_value == cfg.high_count_value) :
                      (result.k_value == result.neighbour_count)))
    else $error("k value does not follow the threshold rule");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !item_ready)
    else $error("item offered acceptance during clearing pass");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for disc_neighbour_pixel_count: pixel loads and disc queries.
module tb_top;
  import dnpc_pkg::*;

  // Geometry of the block as instantiated (default parameters).
  localparam int MAP_ROWS    = 256;
  localparam int MAP_COLS    = 256;
  localparam int RADIUS_CAP  = 15;
  // Settling wait after the last answer, with slack over the longest query or pixel write.
  localparam int SETTLE_CYC  = 60;
  localparam int HOLD_CYCLES = 400;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;
  logic    psel = 1'b0;
  logic    penable = 1'b0;
  logic    pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic    pready;

  // Shadow of the bitmap, updated as beats are accepted, and of the registers.
  bit       pixel_shadow [MAP_ROWS][MAP_COLS];
  int       img_rows  = IMAGE_ROWS_RST;
  int       img_cols  = IMAGE_COLS_RST;
  int       high_k    = HIGH_COUNT_RST;
  int       k_thresh  = COUNT_THRESH_RST;

  item_t    pending_beats[$];
  result_t  expected_counts[$];
  result_t  want_res;
  int       failures = 0;

  // Idling control: calm switches all idling off for the closing stretch,
  // quiet comes and goes by itself so that idle-free stretches also occur.
  logic     calm = 1'b0;
  logic     quiet = 1'b0;
  logic [5:0] epoch = '0;
  logic     hold_start = 1'b0;
  int       hold_left = 0;
  int       gap_left = 0;
  int       stall_left = 0;

  disc_neighbour_pixel_count dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // Count set pixels inside the disc around (crow, ccol), clipped to the image
  // and leaving out the centre. The radius is held in Q.4 and squared exactly.
  function automatic int disc_pixel_count(int crow, int ccol, int nn_q4);
    int rad_q4, rad_sq, span, rows, cols, r, c, total;
    rad_q4 = 3 * nn_q4;
    if (rad_q4 > RADIUS_CAP * 16) rad_q4 = RADIUS_CAP * 16;
    rad_sq = rad_q4 * rad_q4;
    span   = rad_q4 >> 4;
    rows   = (img_rows < MAP_ROWS) ? img_rows : MAP_ROWS;
    cols   = (img_cols < MAP_COLS) ? img_cols : MAP_COLS;
    total  = 0;
    for (int i = -span; i <= span; i++) begin
      r = crow + i;
      if (r < 0 || r >= rows) continue;
      for (int j = -span; j <= span; j++) begin
        c = ccol + j;
        if (c < 0 || c >= cols) continue;
        if (i == 0 && j == 0) continue;
        if ((i * i + j * j) * 256 > rad_sq) continue;
        if (pixel_shadow[r][c]) total++;
      end
    end
    return (total > COUNT_MAX) ? COUNT_MAX : total;
  endfunction

  // Apply one accepted beat to the shadow; a query queues its expected answer.
  task automatic apply_beat(item_t b);
    int n;
    result_t e;
    if (b.cmd == CMD_WRITE) begin
      pixel_shadow[b.pixel_row][b.pixel_col] = b.pixel_set;
    end else begin
      n = disc_pixel_count(b.pixel_row, b.pixel_col, b.nn_distance_q4);
      e.neighbour_count = 10'(n);
      e.k_value         = (n > k_thresh) ? 10'(high_k) : 10'(n);
      expected_counts = {expected_counts, e};
    end
  endtask

  // Sender: advance through the pending beats, inserting idle bursts between them.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (item_valid && item_ready) apply_beat(item);
      // Hold a beat that has not been taken yet.
      if (!item_valid || item_ready) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          item_valid <= 1'b0;
        end else if (pending_beats.size() != 0 && !calm && !quiet &&
                     $urandom_range(0, 7) == 0) begin
          gap_left   <= $urandom_range(0, 4);
          item_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          item       <= pending_beats.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_counts.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: count=%0d k=%0d",
                     result.neighbour_count, result.k_value);
        end else begin
          want_res = expected_counts.pop_front();
          if (result.neighbour_count !== want_res.neighbour_count ||
              result.k_value !== want_res.k_value) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: expected count=%0d k=%0d, got count=%0d k=%0d",
                       want_res.neighbour_count, want_res.k_value,
                       result.neighbour_count, result.k_value);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        result_ready <= 1'b0;
      end else if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left   <= $urandom_range(0, 4);
        result_ready <= 1'b0;
      end else begin
        result_ready <= (hold_left == 0);
      end
    end
  end

  // Long receiver hold, counted here; also redraw the quiet window each time epoch wraps.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      quiet     <= 1'b0;
      epoch     <= '0;
    end else begin
      epoch <= epoch + 1'b1;
      if (epoch == '0) quiet <= ($urandom_range(0, 3) == 0);
      if (hold_start) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
    end
  end

  task automatic push_beat(logic cmd, int row, int col, bit set, int nn);
    item_t b;
    b.cmd            = cmd;
    b.pixel_row      = 8'(row);
    b.pixel_col      = 8'(col);
    b.pixel_set      = set;
    b.nn_distance_q4 = 10'(nn);
    pending_beats = {pending_beats, b};
  endtask

  // Register write: setup cycle, then access cycle; the register takes the write at the end of the access cycle.
  task automatic write_reg(reg_idx_t idx, int unsigned val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_IMAGE_ROWS:   img_rows = val & 32'h1FF;
      REG_IMAGE_COLS:   img_cols = val & 32'h1FF;
      REG_HIGH_COUNT:   high_k   = val & 32'h3FF;
      REG_COUNT_THRESH: k_thresh = val & 32'h3FF;
      default: ;
    endcase
  endtask

  task automatic set_config(int rows, int cols, int high, int thresh);
    write_reg(REG_IMAGE_ROWS, rows);
    write_reg(REG_IMAGE_COLS, cols);
    write_reg(REG_HIGH_COUNT, high);
    write_reg(REG_COUNT_THRESH, thresh);
  endtask

  // Wait until every beat is sent and every answer is in, then let the last
  // write finish before anything touches the registers.
  task automatic settle();
    @(negedge clk);
    while (pending_beats.size() != 0 || item_valid || expected_counts.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Pick a coordinate near the image edges, inside the image, or anywhere.
  function automatic int pick_coord(int lim);
    int eff;
    eff = (lim < 1) ? 1 : ((lim > 256) ? 256 : lim);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return eff - 1;
      2:       return $urandom_range(0, 255);
      default: return $urandom_range(0, eff - 1);
    endcase
  endfunction

  // Random scene: clusters of pixel writes with queries aimed into them,
  // plus stray writes and queries anywhere. Move the cluster every 32 beats.
  task automatic add_scene(int n);
    int cr, cc, pick, nn;
    cr = 0;
    cc = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) begin
        cr = pick_coord(img_rows);
        cc = pick_coord(img_cols);
      end
      pick = $urandom_range(0, 99);
      nn   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 90);
      if (pick < 50)
        push_beat(CMD_WRITE, (cr + $urandom_range(0, 32) - 16) & 255,
                  (cc + $urandom_range(0, 32) - 16) & 255,
                  $urandom_range(0, 9) < 8, $urandom_range(0, 1023));
      else if (pick < 58)
        push_beat(CMD_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 1), $urandom_range(0, 1023));
      else if (pick < 90)
        push_beat(CMD_QUERY, (cr + $urandom_range(0, 8) - 4) & 255,
                  (cc + $urandom_range(0, 8) - 4) & 255, $urandom_range(0, 1), nn);
      else
        push_beat(CMD_QUERY, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 1), $urandom_range(0, 1023));
    end
  endtask

  function automatic int pick_size();
    case ($urandom_range(0, 3))
      0:       return 256;
      1:       return $urandom_range(1, 32);
      default: return $urandom_range(1, 256);
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset register values: empty map, corners,
    // saturated radius, and the count stepping over the threshold.
    push_beat(CMD_QUERY, 0, 0, 1'b0, 0);
    push_beat(CMD_WRITE, 0, 0, 1'b1, 1023);
    push_beat(CMD_WRITE, 0, 1, 1'b1, 0);
    push_beat(CMD_WRITE, 1, 0, 1'b1, 0);
    push_beat(CMD_WRITE, 255, 255, 1'b1, 0);
    push_beat(CMD_WRITE, 254, 255, 1'b1, 0);
    push_beat(CMD_QUERY, 0, 0, 1'b1, 6);
    push_beat(CMD_QUERY, 0, 0, 1'b0, 1023);
    push_beat(CMD_QUERY, 255, 255, 1'b1, 1023);
    push_beat(CMD_WRITE, 0, 0, 1'b0, 0);
    push_beat(CMD_QUERY, 1, 1, 1'b0, 16);
    for (int n = 0; n < 11; n++) begin
      push_beat(CMD_WRITE, 102, 95 + n, 1'b1, 0);
      if (n >= 9) push_beat(CMD_QUERY, 100, 100, 1'b0, 1023);
    end
    settle();

    // Upper register extremes.
    set_config(256, 256, 1023, 960);
    add_scene(150);
    settle();

    // Lower extremes: a one-pixel image, centres mostly outside it.
    set_config(1, 1, 0, 0);
    push_beat(CMD_WRITE, 0, 0, 1'b1, 0);
    push_beat(CMD_QUERY, 0, 1, 1'b0, 16);
    push_beat(CMD_QUERY, 0, 0, 1'b1, 1023);
    add_scene(40);
    settle();

    // Zero rows clip everything; a column count beyond the map is clipped.
    set_config(0, 511, 7, 3);
    add_scene(20);
    settle();

    // Random settings; in the third round the receiver holds off for a long
    // stretch while the sender keeps offering beats.
    for (int ph = 0; ph < 6; ph++) begin
      set_config(pick_size(), pick_size(), $urandom_range(0, 1023), $urandom_range(0, 60));
      add_scene(150);
      if (ph == 2) begin
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      settle();
    end

    // Closing stretch with no idling on either side.
    set_config(pick_size(), pick_size(), $urandom_range(0, 1023), $urandom_range(0, 30));
    calm <= 1'b1;
    add_scene(150);
    settle();

    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
